// ===== sv/hwsl_pkg.sv =====
// Shared types and constants for the wheel speed limiter.
package hwsl_pkg;
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_WS,
        ST_MAX,
        ST_LOAD,
        ST_DIV,
        ST_SLEW,
        ST_OUT
    } t_state;

    // what the shared shift-add multiplier is working on
    typedef enum logic [1:0] {
        PH_SPIN,
        PH_NORM,
        PH_RPM
    } t_phase;

    localparam logic [1:0] CFG_ARM  = 2'd0;
    localparam logic [1:0] CFG_MAXV = 2'd1;
    localparam logic [1:0] CFG_RPM  = 2'd2;
    localparam logic [1:0] CFG_STEP = 2'd3;
endpackage

// ===== sv/holonomic_wheel_speed_limiter_core.sv =====
// Omni-wheel inverse kinematics with speed normalization and RPM slew limit.
// Input channel i_valid / o_stall: one chassis transaction (forward, lateral,
// spin). Output channel o_valid / i_stall: four wheel RPMs and speed_scaled.
// Configuration writes (i_cfg_we, i_cfg_addr, i_cfg_data) must be made only
// while the block is idle; the block itself does not enforce this.
// One transaction at a time. Every product is a shift-add, one multiplier bit
// per cycle; each normalization quotient comes from a restoring divider, one
// quotient bit per cycle.
// After acceptance the block forms the spin product, the wheel speeds and
// the largest speed, then per wheel a load, the RPM product and the slew;
// when the speeds are scaled, a load, normalization product and divide per
// wheel come first. A new transaction is taken the cycle after the result
// leaves.
// While i_stall is high the result holds steady and o_stall stays high.
// Synchronous active-low reset restores the default registers and clears the
// stored RPMs.
module holonomic_wheel_speed_limiter_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_vel_forward,
    input  logic signed [15:0] i_vel_lateral,
    input  logic signed [15:0] i_spin_rate,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_rpm_left_front,
    output logic signed [15:0] o_rpm_right_front,
    output logic signed [15:0] o_rpm_left_back,
    output logic signed [15:0] o_rpm_right_back,
    output logic               o_speed_scaled,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [15:0]        i_cfg_data
);
    hwsl_pkg::t_state r_state, n_state;
    hwsl_pkg::t_phase r_ph;

    logic [15:0] r_arm;
    logic [14:0] r_maxv;
    logic [15:0] r_rps;
    logic [11:0] r_step;

    logic signed [15:0] r_fwd, r_lat;
    logic signed [35:0] r_acc;   // product, then divider remainder:quotient
    logic signed [35:0] r_mcd;   // multiplicand, shifted left each multiply cycle
    logic [15:0]        r_mq;    // multiplier bits shifted out LSB first
    logic [3:0]         r_cnt;
    logic [1:0]         r_wh;
    logic signed [19:0] r_ws [4];
    logic [19:0]        r_big;
    logic               r_scl;
    logic signed [15:0] r_last [4];

    // wheel speeds from the finished spin term
    logic signed [35:0] w_trn_full;
    logic signed [18:0] w_trn;
    logic signed [19:0] w_ws [4];
    always_comb begin
        w_trn_full = r_acc + 36'sd8192;
        w_trn = 19'(w_trn_full >>> 14);
        w_ws[0] = 20'(r_fwd) - 20'(r_lat) - 20'(w_trn);
        w_ws[1] = -20'(r_fwd) - 20'(r_lat) - 20'(w_trn);
        w_ws[2] = 20'(r_fwd) + 20'(r_lat) - 20'(w_trn);
        w_ws[3] = -20'(r_fwd) + 20'(r_lat) - 20'(w_trn);
    end

    // current wheel and running largest magnitude
    logic signed [19:0] w_cur;
    logic [19:0]        w_cur_mag, w_big_nx;
    logic               w_scl_nx;
    always_comb begin
        w_cur = r_ws[r_wh];
        w_cur_mag = w_cur[19] ? 20'(-w_cur) : 20'(w_cur);
        w_big_nx = (w_cur_mag > r_big) ? w_cur_mag : r_big;
        w_scl_nx = w_big_nx > {5'd0, r_maxv};
    end

    // divider step: remainder in [34:15], dividend bits then quotient below
    logic [20:0] w_rem_sh, w_rem_sub;
    logic [14:0] w_quo;
    always_comb begin
        w_rem_sh  = {r_acc[34:15], r_acc[14]};
        w_rem_sub = w_rem_sh - {1'b0, r_big};
        w_quo     = {r_acc[13:0], ~w_rem_sub[20]};
    end

    // rpm rounding and slew for current wheel
    logic signed [35:0] w_rp;
    logic signed [20:0] w_want;
    logic signed [21:0] w_diff, w_cmd, w_stp;
    logic signed [15:0] w_prev, w_sat;
    always_comb begin
        w_prev = r_last[r_wh];
        w_stp = $signed({10'd0, r_step});
        w_rp = r_acc + 36'sd32768;
        w_want = 21'(w_rp >>> 16);
        w_diff = 22'(w_want) - 22'(w_prev);
        if ((w_want > 21'sd0 && w_prev < 16'sd0) || (w_want < 21'sd0 && w_prev > 16'sd0))
            w_cmd = '0;
        else if (w_diff > w_stp)
            w_cmd = 22'(w_prev) + w_stp;
        else if (w_diff < -w_stp)
            w_cmd = 22'(w_prev) - w_stp;
        else
            w_cmd = 22'(w_want);
        if (w_cmd > 22'sd32767) w_sat = 16'sh7fff;
        else if (w_cmd < -22'sd32768) w_sat = 16'sh8000;
        else w_sat = 16'(w_cmd);
    end

    always_comb begin
        n_state = r_state;
        o_stall = (r_state != hwsl_pkg::ST_IDLE);
        o_valid = (r_state == hwsl_pkg::ST_OUT);
        case (r_state)
            hwsl_pkg::ST_IDLE: if (i_valid) n_state = hwsl_pkg::ST_MUL;
            hwsl_pkg::ST_MUL: if (r_cnt == 4'd15) begin
                case (r_ph)
                    hwsl_pkg::PH_SPIN: n_state = hwsl_pkg::ST_WS;
                    hwsl_pkg::PH_NORM: n_state = hwsl_pkg::ST_DIV;
                    default:           n_state = hwsl_pkg::ST_SLEW;
                endcase
            end
            hwsl_pkg::ST_WS:   n_state = hwsl_pkg::ST_MAX;
            hwsl_pkg::ST_MAX:  if (r_wh == 2'd3) n_state = hwsl_pkg::ST_LOAD;
            hwsl_pkg::ST_LOAD: n_state = hwsl_pkg::ST_MUL;
            hwsl_pkg::ST_DIV:  if (r_cnt == 4'd14) n_state = hwsl_pkg::ST_LOAD;
            hwsl_pkg::ST_SLEW:
                n_state = (r_wh == 2'd3) ? hwsl_pkg::ST_OUT : hwsl_pkg::ST_LOAD;
            hwsl_pkg::ST_OUT: if (!i_stall) n_state = hwsl_pkg::ST_IDLE;
            default: n_state = hwsl_pkg::ST_IDLE;
        endcase
    end

    assign o_rpm_left_front  = r_last[0];
    assign o_rpm_right_front = r_last[1];
    assign o_rpm_left_back   = r_last[2];
    assign o_rpm_right_back  = r_last[3];
    assign o_speed_scaled    = r_scl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hwsl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm  <= 16'd27800;
            r_maxv <= 15'd12288;
            r_rps  <= 16'd38192;
            r_step <= 12'd100;
            for (int k = 0; k < 4; k++) r_last[k] <= '0;
            r_cnt <= '0;
            r_wh <= '0;
            r_ph <= hwsl_pkg::PH_SPIN;
            r_scl <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    hwsl_pkg::CFG_ARM:  r_arm  <= i_cfg_data;
                    hwsl_pkg::CFG_MAXV: r_maxv <= i_cfg_data[14:0];
                    hwsl_pkg::CFG_RPM:  r_rps  <= i_cfg_data;
                    hwsl_pkg::CFG_STEP: r_step <= i_cfg_data[11:0];
                    default: ;
                endcase
            end
            case (r_state)
                hwsl_pkg::ST_IDLE: if (i_valid) begin
                    r_fwd <= i_vel_forward;
                    r_lat <= i_vel_lateral;
                    r_mcd <= 36'(i_spin_rate);
                    r_mq  <= r_arm;
                    r_acc <= '0;
                    r_cnt <= '0;
                    r_ph  <= hwsl_pkg::PH_SPIN;
                end
                hwsl_pkg::ST_MUL: begin
                    if (r_mq[0]) r_acc <= r_acc + r_mcd;
                    r_mcd <= r_mcd <<< 1;
                    r_mq  <= r_mq >> 1;
                    r_cnt <= r_cnt + 4'd1;
                end
                hwsl_pkg::ST_WS: begin
                    for (int k = 0; k < 4; k++) r_ws[k] <= w_ws[k];
                    r_big <= '0;
                    r_wh  <= '0;
                end
                hwsl_pkg::ST_MAX: begin
                    r_big <= w_big_nx;
                    r_wh  <= r_wh + 2'd1;
                    if (r_wh == 2'd3) begin
                        r_scl <= w_scl_nx;
                        r_ph  <= w_scl_nx ? hwsl_pkg::PH_NORM : hwsl_pkg::PH_RPM;
                    end
                end
                hwsl_pkg::ST_LOAD: begin
                    r_acc <= '0;
                    r_cnt <= '0;
                    if (r_ph == hwsl_pkg::PH_NORM) begin
                        r_mcd <= 36'(w_cur_mag);
                        r_mq  <= {1'b0, r_maxv};
                    end else begin
                        r_mcd <= 36'(w_cur);
                        r_mq  <= r_rps;
                    end
                end
                hwsl_pkg::ST_DIV: begin
                    if (!w_rem_sub[20])
                        r_acc <= 36'({w_rem_sub[19:0], r_acc[13:0], 1'b1});
                    else
                        r_acc <= 36'({w_rem_sh[19:0], r_acc[13:0], 1'b0});
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd14) begin
                        r_ws[r_wh] <= w_cur[19] ? -20'(w_quo) : 20'(w_quo);
                        r_wh <= r_wh + 2'd1;
                        if (r_wh == 2'd3) r_ph <= hwsl_pkg::PH_RPM;
                    end
                end
                hwsl_pkg::ST_SLEW: begin
                    r_last[r_wh] <= w_sat;
                    r_wh <= r_wh + 2'd1;
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== verif/testbench.sv =====
// Testbench for holonomic_wheel_speed_limiter_core: directed and random chassis commands.
module testbench;
    localparam int CYCLE_LIMIT = 6000000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [15:0] i_vel_forward;
    logic signed [15:0] i_vel_lateral;
    logic signed [15:0] i_spin_rate;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_rpm_left_front;
    logic signed [15:0] o_rpm_right_front;
    logic signed [15:0] o_rpm_left_back;
    logic signed [15:0] o_rpm_right_back;
    logic               o_speed_scaled;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_addr;
    logic [15:0]        i_cfg_data;

    typedef struct packed {
        logic signed [15:0] lf;
        logic signed [15:0] rf;
        logic signed [15:0] lb;
        logic signed [15:0] rb;
        logic               scaled;
    } t_wheel_cmd;

    // predictor state
    logic [15:0]        arm_q16;
    logic [14:0]        vmax_q12;
    logic [15:0]        rpm_gain;
    logic [11:0]        rpm_step;
    logic signed [15:0] prev_rpm [4];

    t_wheel_cmd expected_cmds [$];
    int  n_errors;
    int  n_sent;
    int  n_checked;
    int  n_scaled;
    int  n_reversals;
    longint cycles;
    bit  quiet_mode;     // no idling on either side
    bit  hold_rx;        // receiver long hold-off
    int  hold_cycles;

    holonomic_wheel_speed_limiter_core u_dut (.*);

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("holonomic_wheel_speed_limiter_core regression: fail");
            $finish;
        end
    end

    function automatic logic signed [63:0] floor_shr(logic signed [63:0] x, int n);
        return x >>> n;
    endfunction

    function automatic t_wheel_cmd compute_wheel_cmd(logic signed [15:0] fwd,
                                                     logic signed [15:0] lat,
                                                     logic signed [15:0] spin);
        logic signed [63:0] turn, largest, lim, q, want, diff, cmd, prev, stp;
        logic signed [63:0] ws [4];
        t_wheel_cmd r;
        turn = floor_shr(64'(spin) * $signed({48'd0, arm_q16}) + 8192, 14);
        ws[0] = fwd - lat - turn;
        ws[1] = -64'(fwd) - lat - turn;
        ws[2] = fwd + lat - turn;
        ws[3] = -64'(fwd) + lat - turn;
        largest = 0;
        lim = $signed({49'd0, vmax_q12});
        for (int i = 0; i < 4; i++)
            if ((ws[i] < 0 ? -ws[i] : ws[i]) > largest)
                largest = ws[i] < 0 ? -ws[i] : ws[i];
        r.scaled = largest > lim;
        if (r.scaled)
            for (int i = 0; i < 4; i++) begin
                q = ((ws[i] < 0 ? -ws[i] : ws[i]) * lim) / largest;
                ws[i] = ws[i] < 0 ? -q : q;
            end
        stp = $signed({52'd0, rpm_step});
        for (int i = 0; i < 4; i++) begin
            want = floor_shr(ws[i] * $signed({48'd0, rpm_gain}) + 32768, 16);
            prev = prev_rpm[i];
            diff = want - prev;
            if ((want > 0 && prev < 0) || (want < 0 && prev > 0)) begin
                cmd = 0;
                n_reversals++;
            end else if (diff > stp) cmd = prev + stp;
            else if (diff < -stp) cmd = prev - stp;
            else cmd = want;
            if (cmd > 32767) cmd = 32767;
            if (cmd < -32768) cmd = -32768;
            prev_rpm[i] = cmd[15:0];
        end
        r.lf = prev_rpm[0];
        r.rf = prev_rpm[1];
        r.lb = prev_rpm[2];
        r.rb = prev_rpm[3];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d (result %0d)",
                 what, got, want, n_checked);
        n_errors++;
    endtask

    // receiver: stall driven at falling edge, results checked at rising edge
    always @(negedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else if (hold_rx) i_stall <= 1'b1;
        else i_stall <= !quiet_mode && ($urandom_range(99) < 36);
    end

    always @(posedge i_clk) begin
        t_wheel_cmd e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_cmds.size() == 0) begin
                report_mismatch("pending transactions", 0, 1);
            end else begin
                e = expected_cmds.pop_front();
                if (o_rpm_left_front !== e.lf)
                    report_mismatch("rpm_left_front", o_rpm_left_front, e.lf);
                if (o_rpm_right_front !== e.rf)
                    report_mismatch("rpm_right_front", o_rpm_right_front, e.rf);
                if (o_rpm_left_back !== e.lb)
                    report_mismatch("rpm_left_back", o_rpm_left_back, e.lb);
                if (o_rpm_right_back !== e.rb)
                    report_mismatch("rpm_right_back", o_rpm_right_back, e.rb);
                if (o_speed_scaled !== e.scaled)
                    report_mismatch("speed_scaled", o_speed_scaled, e.scaled);
                if (e.scaled) n_scaled++;
            end
            n_checked++;
        end
    end

    // long receiver hold-off, counted here
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_rx <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            hold_rx <= 1'b0;
        end
    end

    task automatic send_command(logic signed [15:0] fwd, logic signed [15:0] lat,
                                logic signed [15:0] spin);
        while (!quiet_mode && $urandom_range(99) < 36) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_vel_forward <= fwd;
        i_vel_lateral <= lat;
        i_spin_rate   <= spin;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_cmds.push_back(compute_wheel_cmd(fwd, lat, spin));
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_cmds.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] addr, logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(negedge i_clk);
        case (addr)
            hwsl_pkg::CFG_ARM:  arm_q16  = data;
            hwsl_pkg::CFG_MAXV: vmax_q12 = data[14:0];
            hwsl_pkg::CFG_RPM:  rpm_gain = data;
            hwsl_pkg::CFG_STEP: rpm_step = data[11:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [15:0] arm, logic [14:0] vmax, logic [15:0] gain,
                              logic [11:0] stp);
        wait_drained();
        write_reg(hwsl_pkg::CFG_ARM, arm);
        write_reg(hwsl_pkg::CFG_MAXV, {1'b0, vmax});
        write_reg(hwsl_pkg::CFG_RPM, gain);
        write_reg(hwsl_pkg::CFG_STEP, {4'd0, stp});
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_field(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(2000)) - 1000);
            default: return 16'($signed($urandom_range(16000)) - 8000);
        endcase
    endfunction

    task automatic test_directed_extremes();
        logic signed [15:0] ext [4] = '{16'sh7fff, -16'sh8000, 16'sd0, -16'sd1};
        foreach (ext[k]) send_command(ext[k], ext[(k + 1) % 4], ext[(k + 2) % 4]);
        send_command(16'sd4096, 16'sd0, 16'sd0);
        send_command(16'sd4096, 16'sd0, 16'sd0);
        send_command(-16'sd4096, 16'sd0, 16'sd0);   // sign reversal
        send_command(16'sd0, 16'sd0, 16'sd1024);
        send_command(16'sd0, -16'sd8000, -16'sd5000);
        send_command(16'sh5555, -16'sh5556, 16'sh2aaa);
    endtask

    task automatic test_config_extremes();
        // zero speed limit and zero step
        set_config(16'd0, 15'd0, 16'd38192, 12'd0);
        send_command(16'sd3000, 16'sd0, 16'sd0);
        send_command(16'sd0, 16'sd0, 16'sd0);
        // everything maxed: saturation and full-range arm
        set_config(16'hffff, 15'h7fff, 16'hffff, 12'hfff);
        for (int k = 0; k < 12; k++)
            send_command(16'sh7fff, (k % 2) ? -16'sh8000 : 16'sh7fff, -16'sh8000);
        send_command(-16'sh8000, 16'sh7fff, 16'sh7fff);
    endtask

    task automatic run_random(int count);
        for (int k = 0; k < count; k++)
            send_command(rand_field($urandom_range(2)), rand_field($urandom_range(2)),
                         rand_field($urandom_range(2)));
    endtask

    task automatic test_random_configs();
        for (int p = 0; p < 6; p++) begin
            set_config(16'($urandom), 15'($urandom), 16'($urandom), 12'($urandom));
            run_random(200);
        end
        set_config(16'd27800, 15'd12288, 16'd38192, 12'd100);
        quiet_mode = 1'b1;
        run_random(200);
        quiet_mode = 1'b0;
        run_random(200);
    endtask

    task automatic test_backpressure();
        // receiver holds off while sender keeps offering transactions
        wait_drained();
        hold_cycles = 600;
        run_random(5);
        run_random(100);
        // sender pauses until everything has drained
        wait_drained();
        run_random(100);
    endtask

    initial begin
        cycles = 0; n_errors = 0; n_sent = 0; n_checked = 0; n_scaled = 0;
        n_reversals = 0; quiet_mode = 1'b0; hold_cycles = 0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_stall = 1'b0; hold_rx = 1'b0;
        i_vel_forward = '0; i_vel_lateral = '0; i_spin_rate = '0;
        i_cfg_we = 1'b0; i_cfg_addr = hwsl_pkg::CFG_ARM; i_cfg_data = '0;
        arm_q16 = 16'd27800; vmax_q12 = 15'd12288; rpm_gain = 16'd38192;
        rpm_step = 12'd100;
        foreach (prev_rpm[k]) prev_rpm[k] = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_extremes();
        test_config_extremes();
        test_random_configs();
        test_backpressure();
        wait_drained();
        $display("sent %0d chassis transactions, checked %0d wheel results", n_sent, n_checked);
        $display("%0d results were speed-scaled, %0d wheel sign reversals", n_scaled,
                 n_reversals);
        if (n_errors == 0)
            $display("holonomic_wheel_speed_limiter_core regression: pass");
        else
            $display("holonomic_wheel_speed_limiter_core regression: fail");
        $finish;
    end
endmodule

// ===== holonomic_wheel_speed_limiter_core.f =====
sv/hwsl_pkg.sv
sv/holonomic_wheel_speed_limiter_core.sv
verif/testbench.sv
